[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define CAU_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cau assertion failed");

// Antecedent implies consequent (a property or a delayed sequence).
`define CAU_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cau assertion failed");

`endif

[hw/rtl/cau_pkg.sv]
// ---------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation and status codes, and the control word carried down the pipeline.
// ---------------------------------------------------------------------------
package cau_pkg;

    localparam int OP_W = 3;
    localparam int ST_W = 2;

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_CONJ = 3'd4;
    localparam logic [OP_W-1:0] OP_MAG  = 3'd5;
    localparam logic [OP_W-1:0] OP_MAG2 = 3'd6;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_SAT  = 2'd1;
    localparam logic [ST_W-1:0] ST_DIVZ = 2'd2;

    typedef struct packed {
        logic            valid;
        logic [OP_W-1:0] op;
        logic            dz;
    } cau_ctrl_t;

endpackage

[hw/rtl/cau_iter.sv]
// ---------------------------------------------------------------------------
// Divide and square root pipeline
// One quotient bit per stage for both parts of the quotient, and one root
// bit per stage over the first DATA_WIDTH stages. Side data rides along.
// ---------------------------------------------------------------------------
module cau_iter #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cau_pkg::cau_ctrl_t            head_ctrl,
    input  logic [DATA_WIDTH-1:0]         head_fr_re,
    input  logic [DATA_WIDTH-1:0]         head_fr_im,
    input  logic                          head_fr_sat,
    input  logic                          head_neg_re,
    input  logic                          head_neg_im,
    input  logic [2*DATA_WIDTH-1:0]       head_den,
    input  logic [2*DATA_WIDTH-1:0]       head_num_re,
    input  logic [2*DATA_WIDTH-1:0]       head_num_im,
    input  logic [2*DATA_WIDTH-1:0]       head_sq,
    output cau_pkg::cau_ctrl_t            tail_ctrl,
    output logic [DATA_WIDTH-1:0]         tail_fr_re,
    output logic [DATA_WIDTH-1:0]         tail_fr_im,
    output logic                          tail_fr_sat,
    output logic                          tail_neg_re,
    output logic                          tail_neg_im,
    output logic [2*DATA_WIDTH+FRAC_BITS-1:0] tail_quo_re,
    output logic [2*DATA_WIDTH+FRAC_BITS-1:0] tail_quo_im,
    output logic [DATA_WIDTH-1:0]         tail_root
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int NW = PW + FRAC_BITS;
    localparam int NS = NW;
    localparam int RW = W + 2;

    cau_ctrl_t       ctrl_reg   [1:NS];
    logic [W-1:0]    fr_re_reg  [1:NS];
    logic [W-1:0]    fr_im_reg  [1:NS];
    logic            fr_sat_reg [1:NS];
    logic            neg_re_reg [1:NS];
    logic            neg_im_reg [1:NS];
    logic [PW-1:0]   den_reg    [1:NS-1];
    logic [NW-1:0]   nsh_re_reg [1:NS-1];
    logic [NW-1:0]   nsh_im_reg [1:NS-1];
    logic [PW-1:0]   rem_re_reg [1:NS-1];
    logic [PW-1:0]   rem_im_reg [1:NS-1];
    logic [NW-1:0]   quo_re_reg [1:NS];
    logic [NW-1:0]   quo_im_reg [1:NS];
    logic [PW-1:0]   sq_n_reg   [1:NS-1];
    logic [RW-1:0]   sq_rem_reg [1:NS-1];
    logic [W-1:0]    root_reg   [1:NS];

    logic [PW-1:0]   cur_den    [0:NS-1];
    logic [NW-1:0]   cur_nsh_re [0:NS-1];
    logic [NW-1:0]   cur_nsh_im [0:NS-1];
    logic [PW-1:0]   cur_rem_re [0:NS-1];
    logic [PW-1:0]   cur_rem_im [0:NS-1];
    logic [NW-1:0]   cur_quo_re [0:NS-1];
    logic [NW-1:0]   cur_quo_im [0:NS-1];
    logic [PW-1:0]   cur_sq_n   [0:NS-1];
    logic [RW-1:0]   cur_sq_rem [0:NS-1];
    logic [W-1:0]    cur_root   [0:NS-1];

    logic [PW-1:0]   rem_re_next [0:NS-1];
    logic [PW-1:0]   rem_im_next [0:NS-1];
    logic [NW-1:0]   quo_re_next [0:NS-1];
    logic [NW-1:0]   quo_im_next [0:NS-1];
    logic [PW-1:0]   sq_n_next   [0:NS-1];
    logic [RW-1:0]   sq_rem_next [0:NS-1];
    logic [W-1:0]    root_next   [0:NS-1];

    always_comb
    begin
        cur_den[0]    = head_den;
        cur_nsh_re[0] = {head_num_re, {FRAC_BITS{1'b0}}};
        cur_nsh_im[0] = {head_num_im, {FRAC_BITS{1'b0}}};
        cur_rem_re[0] = '0;
        cur_rem_im[0] = '0;
        cur_quo_re[0] = '0;
        cur_quo_im[0] = '0;
        cur_sq_n[0]   = head_sq;
        cur_sq_rem[0] = '0;
        cur_root[0]   = '0;
        for (int k = 1; k < NS; k++)
        begin
            cur_den[k]    = den_reg[k];
            cur_nsh_re[k] = nsh_re_reg[k];
            cur_nsh_im[k] = nsh_im_reg[k];
            cur_rem_re[k] = rem_re_reg[k];
            cur_rem_im[k] = rem_im_reg[k];
            cur_quo_re[k] = quo_re_reg[k];
            cur_quo_im[k] = quo_im_reg[k];
            cur_sq_n[k]   = sq_n_reg[k];
            cur_sq_rem[k] = sq_rem_reg[k];
            cur_root[k]   = root_reg[k];
        end
    end

    // One restoring step per part, one root digit per stage
    always_comb
    begin
        logic [PW:0]   t_re;
        logic [PW:0]   t_im;
        logic          ge_re;
        logic          ge_im;
        logic [RW+1:0] t_sq;
        logic [RW+1:0] trial;
        logic          ge_sq;
        for (int k = 0; k < NS; k++)
        begin
            t_re  = {cur_rem_re[k], cur_nsh_re[k][NW-1]};
            t_im  = {cur_rem_im[k], cur_nsh_im[k][NW-1]};
            ge_re = t_re >= {1'b0, cur_den[k]};
            ge_im = t_im >= {1'b0, cur_den[k]};
            rem_re_next[k] = ge_re ? PW'(t_re - {1'b0, cur_den[k]}) : t_re[PW-1:0];
            rem_im_next[k] = ge_im ? PW'(t_im - {1'b0, cur_den[k]}) : t_im[PW-1:0];
            quo_re_next[k] = {cur_quo_re[k][NW-2:0], ge_re};
            quo_im_next[k] = {cur_quo_im[k][NW-2:0], ge_im};

            t_sq  = {cur_sq_rem[k], cur_sq_n[k][PW-1:PW-2]};
            trial = (RW+2)'({cur_root[k], 2'b01});
            ge_sq = t_sq >= trial;
            if (k < W)
            begin
                sq_rem_next[k] = ge_sq ? RW'(t_sq - trial) : RW'(t_sq);
                root_next[k]   = {cur_root[k][W-2:0], ge_sq};
                sq_n_next[k]   = {cur_sq_n[k][PW-3:0], 2'b00};
            end
            else
            begin
                sq_rem_next[k] = cur_sq_rem[k];
                root_next[k]   = cur_root[k];
                sq_n_next[k]   = cur_sq_n[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= NS; k++)
            begin
                ctrl_reg[k] <= '0;
            end
        end
        else
        begin
            ctrl_reg[1] <= head_ctrl;
            for (int k = 2; k <= NS; k++)
            begin
                ctrl_reg[k] <= ctrl_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fr_re_reg[1]  <= head_fr_re;
        fr_im_reg[1]  <= head_fr_im;
        fr_sat_reg[1] <= head_fr_sat;
        neg_re_reg[1] <= head_neg_re;
        neg_im_reg[1] <= head_neg_im;
        for (int k = 2; k <= NS; k++)
        begin
            fr_re_reg[k]  <= fr_re_reg[k-1];
            fr_im_reg[k]  <= fr_im_reg[k-1];
            fr_sat_reg[k] <= fr_sat_reg[k-1];
            neg_re_reg[k] <= neg_re_reg[k-1];
            neg_im_reg[k] <= neg_im_reg[k-1];
        end
        // Working state is only needed up to the last stage's input
        for (int k = 0; k < NS - 1; k++)
        begin
            den_reg[k+1]    <= cur_den[k];
            nsh_re_reg[k+1] <= {cur_nsh_re[k][NW-2:0], 1'b0};
            nsh_im_reg[k+1] <= {cur_nsh_im[k][NW-2:0], 1'b0};
            rem_re_reg[k+1] <= rem_re_next[k];
            rem_im_reg[k+1] <= rem_im_next[k];
            sq_n_reg[k+1]   <= sq_n_next[k];
            sq_rem_reg[k+1] <= sq_rem_next[k];
        end
        for (int k = 0; k < NS; k++)
        begin
            quo_re_reg[k+1] <= quo_re_next[k];
            quo_im_reg[k+1] <= quo_im_next[k];
            root_reg[k+1]   <= root_next[k];
        end
    end

    assign tail_ctrl   = ctrl_reg[NS];
    assign tail_fr_re  = fr_re_reg[NS];
    assign tail_fr_im  = fr_im_reg[NS];
    assign tail_fr_sat = fr_sat_reg[NS];
    assign tail_neg_re = neg_re_reg[NS];
    assign tail_neg_im = neg_im_reg[NS];
    assign tail_quo_re = quo_re_reg[NS];
    assign tail_quo_im = quo_im_reg[NS];
    assign tail_root   = root_reg[NS];

endmodule

[hw/rtl/complex_arithmetic_unit.sv]
// ---------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, conjugate, magnitude and squared magnitude
// of complex fixed-point operands, with saturation and status flags.
// ---------------------------------------------------------------------------
// A transaction is taken whenever start is high; busy stays low, so one
// transaction may enter every cycle. Each result appears on done in order,
// after the operand, product, sum and setup registers, the divider stages
// and the output register. The divider resolves one quotient bit per stage
// over 2*DATA_WIDTH + FRAC_BITS stages; the square root runs in the first
// DATA_WIDTH of those stages, and every operation takes the same path
// length. The result is held for one cycle only.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cau_pkg::OP_W-1:0]      operation,
    input  logic signed [DATA_WIDTH-1:0]  a_re,
    input  logic signed [DATA_WIDTH-1:0]  a_im,
    input  logic signed [DATA_WIDTH-1:0]  b_re,
    input  logic signed [DATA_WIDTH-1:0]  b_im,
    output logic                          done,
    output logic signed [DATA_WIDTH-1:0]  res_re,
    output logic signed [DATA_WIDTH-1:0]  res_im,
    output logic                          res_is_zero,
    output logic                          res_is_real,
    output logic [cau_pkg::ST_W-1:0]      status
);
    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;
    localparam int NW = PW + FRAC_BITS;

    // Clamp a wide signed value into W bits; MSB of the result is the flag
    function automatic logic [W:0] sat_s(input logic signed [PW:0] v);
        logic signed [PW:0] hi;
        logic signed [PW:0] lo;
        logic [W:0]         r;
        hi = $signed({{(PW-W+2){1'b0}}, {(W-1){1'b1}}});
        lo = ~hi;
        if (v > hi)
            r = {1'b1, hi[W-1:0]};
        else if (v < lo)
            r = {1'b1, lo[W-1:0]};
        else
            r = {1'b0, v[W-1:0]};
        return r;
    endfunction

    // Stage 1: operand capture
    cau_ctrl_t          c1_reg;
    logic signed [W-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;

    // Stage 2: products
    cau_ctrl_t           c2_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, p_bb_reg, p_cc_reg;
    logic signed [W:0]    e_re2_reg, e_im2_reg;

    // Stage 3: sums
    cau_ctrl_t           c3_reg;
    logic signed [PW:0]  sr_reg, si_reg;
    logic [PW-1:0]       den3_reg;
    logic signed [W:0]   e_re3_reg, e_im3_reg;

    // Stage 4: iteration setup and direct results
    cau_ctrl_t           c4_reg;
    logic [W-1:0]        fr_re4_reg, fr_im4_reg;
    logic                fr_sat4_reg;
    logic                neg_re4_reg, neg_im4_reg;
    logic [PW-1:0]       den4_reg, num_re4_reg, num_im4_reg, sq4_reg;

    // Output
    logic                done_reg;
    logic [W-1:0]        res_re_reg, res_im_reg;
    logic                is_zero_reg, is_real_reg;
    logic [ST_W-1:0]     status_reg;

    logic signed [W-1:0] mb_re, mb_im;
    logic signed [W:0]   e_re_next, e_im_next;
    logic signed [PW:0]  sr_next, si_next;
    logic [PW:0]         den_sum;
    logic [W:0]          q_re, q_im;
    logic signed [PW:0]  sh_re, sh_im;
    logic [W-1:0]        fr_re_next, fr_im_next;
    logic                fr_sat_next;
    logic signed [PW:0]  abs_re, abs_im;

    cau_ctrl_t           t_ctrl;
    logic [W-1:0]        t_fr_re, t_fr_im;
    logic                t_fr_sat, t_neg_re, t_neg_im;
    logic [NW-1:0]       t_quo_re, t_quo_im;
    logic [W-1:0]        t_root;

    logic [W-1:0]        o_re_next, o_im_next;
    logic                o_sat_next;
    logic [ST_W-1:0]     o_status_next;

    assign busy = 1'b0;

    // ---- stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c1_reg <= '0;
        else
        begin
            c1_reg.valid <= start && !busy;
            c1_reg.op    <= operation;
            c1_reg.dz    <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ar1_reg <= a_re;
        ai1_reg <= a_im;
        br1_reg <= b_re;
        bi1_reg <= b_im;
    end

    // ---- stage 2: magnitude ops square A through the same multipliers
    always_comb
    begin
        if (c1_reg.op == OP_MAG || c1_reg.op == OP_MAG2)
        begin
            mb_re = ar1_reg;
            mb_im = ai1_reg;
        end
        else
        begin
            mb_re = br1_reg;
            mb_im = bi1_reg;
        end
        case (c1_reg.op)
            OP_ADD:
            begin
                e_re_next = (W+1)'(ar1_reg) + (W+1)'(br1_reg);
                e_im_next = (W+1)'(ai1_reg) + (W+1)'(bi1_reg);
            end
            OP_SUB:
            begin
                e_re_next = (W+1)'(ar1_reg) - (W+1)'(br1_reg);
                e_im_next = (W+1)'(ai1_reg) - (W+1)'(bi1_reg);
            end
            OP_CONJ:
            begin
                e_re_next = (W+1)'(ar1_reg);
                e_im_next = -((W+1)'(ai1_reg));
            end
            default:
            begin
                e_re_next = '0;
                e_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c2_reg <= '0;
        else
            c2_reg <= c1_reg;
    end

    always_ff @(posedge clk)
    begin
        p_rr_reg  <= ar1_reg * mb_re;
        p_ii_reg  <= ai1_reg * mb_im;
        p_ir_reg  <= ai1_reg * br1_reg;
        p_ri_reg  <= ar1_reg * bi1_reg;
        p_bb_reg  <= br1_reg * br1_reg;
        p_cc_reg  <= bi1_reg * bi1_reg;
        e_re2_reg <= e_re_next;
        e_im2_reg <= e_im_next;
    end

    // ---- stage 3
    always_comb
    begin
        case (c2_reg.op)
            OP_MUL:
            begin
                sr_next = (PW+1)'(p_rr_reg) - (PW+1)'(p_ii_reg);
                si_next = (PW+1)'(p_ri_reg) + (PW+1)'(p_ir_reg);
            end
            OP_DIV:
            begin
                sr_next = (PW+1)'(p_rr_reg) + (PW+1)'(p_ii_reg);
                si_next = (PW+1)'(p_ir_reg) - (PW+1)'(p_ri_reg);
            end
            OP_MAG, OP_MAG2:
            begin
                sr_next = (PW+1)'(p_rr_reg) + (PW+1)'(p_ii_reg);
                si_next = '0;
            end
            default:
            begin
                sr_next = '0;
                si_next = '0;
            end
        endcase
        den_sum = {1'b0, p_bb_reg} + {1'b0, p_cc_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c3_reg <= '0;
        else
            c3_reg <= c2_reg;
    end

    always_ff @(posedge clk)
    begin
        sr_reg    <= sr_next;
        si_reg    <= si_next;
        den3_reg  <= den_sum[PW-1:0];
        e_re3_reg <= e_re2_reg;
        e_im3_reg <= e_im2_reg;
    end

    // ---- stage 4: floor shift and clamp for direct results
    always_comb
    begin
        sh_re = sr_reg >>> FRAC_BITS;
        sh_im = si_reg >>> FRAC_BITS;
        case (c3_reg.op)
            OP_ADD, OP_SUB, OP_CONJ:
            begin
                q_re = sat_s((PW+1)'(e_re3_reg));
                q_im = sat_s((PW+1)'(e_im3_reg));
            end
            OP_MUL:
            begin
                q_re = sat_s(sh_re);
                q_im = sat_s(sh_im);
            end
            OP_MAG2:
            begin
                q_re = sat_s(sh_re);
                q_im = '0;
            end
            default:
            begin
                q_re = '0;
                q_im = '0;
            end
        endcase
        fr_re_next  = q_re[W-1:0];
        fr_im_next  = q_im[W-1:0];
        fr_sat_next = q_re[W] | q_im[W];
        abs_re = sr_reg[PW] ? -sr_reg : sr_reg;
        abs_im = si_reg[PW] ? -si_reg : si_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c4_reg <= '0;
        else
        begin
            c4_reg.valid <= c3_reg.valid;
            c4_reg.op    <= c3_reg.op;
            c4_reg.dz    <= den3_reg == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        fr_re4_reg  <= fr_re_next;
        fr_im4_reg  <= fr_im_next;
        fr_sat4_reg <= fr_sat_next;
        neg_re4_reg <= sr_reg[PW];
        neg_im4_reg <= si_reg[PW];
        den4_reg    <= den3_reg;
        num_re4_reg <= abs_re[PW-1:0];
        num_im4_reg <= abs_im[PW-1:0];
        sq4_reg     <= sr_reg[PW-1:0];
    end

    cau_iter #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_iter (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_ctrl   (c4_reg),
        .head_fr_re  (fr_re4_reg),
        .head_fr_im  (fr_im4_reg),
        .head_fr_sat (fr_sat4_reg),
        .head_neg_re (neg_re4_reg),
        .head_neg_im (neg_im4_reg),
        .head_den    (den4_reg),
        .head_num_re (num_re4_reg),
        .head_num_im (num_im4_reg),
        .head_sq     (sq4_reg),
        .tail_ctrl   (t_ctrl),
        .tail_fr_re  (t_fr_re),
        .tail_fr_im  (t_fr_im),
        .tail_fr_sat (t_fr_sat),
        .tail_neg_re (t_neg_re),
        .tail_neg_im (t_neg_im),
        .tail_quo_re (t_quo_re),
        .tail_quo_im (t_quo_im),
        .tail_root   (t_root)
    );

    // ---- output: clamp quotient and root, pick the result
    always_comb
    begin
        logic [NW-1:0] lim;
        logic          sat_re, sat_im;
        logic [W-1:0]  v_re, v_im;
        lim = NW'(1) << (W - 1);
        if (t_neg_re)
        begin
            sat_re = t_quo_re > lim;
            v_re   = sat_re ? lim[W-1:0] : W'(0) - t_quo_re[W-1:0];
        end
        else
        begin
            sat_re = t_quo_re > lim - NW'(1);
            v_re   = sat_re ? W'(lim - NW'(1)) : t_quo_re[W-1:0];
        end
        if (t_neg_im)
        begin
            sat_im = t_quo_im > lim;
            v_im   = sat_im ? lim[W-1:0] : W'(0) - t_quo_im[W-1:0];
        end
        else
        begin
            sat_im = t_quo_im > lim - NW'(1);
            v_im   = sat_im ? W'(lim - NW'(1)) : t_quo_im[W-1:0];
        end
        case (t_ctrl.op)
            OP_DIV:
            begin
                if (t_ctrl.dz)
                begin
                    o_re_next  = '0;
                    o_im_next  = '0;
                    o_sat_next = 1'b0;
                end
                else
                begin
                    o_re_next  = v_re;
                    o_im_next  = v_im;
                    o_sat_next = sat_re | sat_im;
                end
            end
            OP_MAG:
            begin
                o_sat_next = t_root[W-1];
                o_re_next  = t_root[W-1] ? W'(lim - NW'(1)) : t_root;
                o_im_next  = '0;
            end
            default:
            begin
                o_re_next  = t_fr_re;
                o_im_next  = t_fr_im;
                o_sat_next = t_fr_sat;
            end
        endcase
        if (t_ctrl.op == OP_DIV && t_ctrl.dz)
            o_status_next = ST_DIVZ;
        else if (o_sat_next)
            o_status_next = ST_SAT;
        else
            o_status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= t_ctrl.valid;
    end

    always_ff @(posedge clk)
    begin
        res_re_reg  <= o_re_next;
        res_im_reg  <= o_im_next;
        is_zero_reg <= (o_re_next == '0) && (o_im_next == '0);
        is_real_reg <= o_im_next == '0;
        status_reg  <= o_status_next;
    end

    assign done        = done_reg;
    assign res_re      = res_re_reg;
    assign res_im      = res_im_reg;
    assign res_is_zero = is_zero_reg;
    assign res_is_real = is_real_reg;
    assign status      = status_reg;

endmodule

[hw/rtl/cau_checker.sv]
// ---------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level checks on latency and result flag consistency.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cau_checker #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          done,
    input logic signed [DATA_WIDTH-1:0]  res_re,
    input logic signed [DATA_WIDTH-1:0]  res_im,
    input logic                          res_is_zero,
    input logic                          res_is_real,
    input logic [cau_pkg::ST_W-1:0]      status
);
    import cau_pkg::*;

    localparam int LAT = 5 + 2 * DATA_WIDTH + FRAC_BITS;

    logic divz_ok;
    logic flags_ok;

    assign divz_ok  = (res_re == '0) && (res_im == '0) && res_is_zero;
    assign flags_ok = (res_is_real == (res_im == '0))
                      && (res_is_zero == (res_is_real && res_re == '0));

    `CAU_ASSERT_IMPLY(a_latency, start && !busy, ##LAT done)
    `CAU_ASSERT_IMPLY(a_no_spurious, !(start && !busy), ##LAT !done)
    `CAU_ASSERT_IMPLY(a_divz_zero, done && status == ST_DIVZ, divz_ok)
    `CAU_ASSERT_IMPLY(a_flags, done, flags_ok)
    `CAU_ASSERT_IMPLY(a_status, done, status == ST_OK || status == ST_SAT || status == ST_DIVZ)

endmodule

bind complex_arithmetic_unit cau_checker #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
) u_cau_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .res_re      (res_re),
    .res_im      (res_im),
    .res_is_zero (res_is_zero),
    .res_is_real (res_is_real),
    .status      (status)
);

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives operand pairs and operation codes through the unit, predicts each
// result with a bit-accurate fixed-point model and checks results in order.
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cau_pkg::*;

    localparam int DW      = 16;
    localparam int FB      = 8;
    localparam int LATENCY = 5 + 2*DW + FB;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 is_zero;
        logic                 is_real;
        logic [ST_W-1:0]      st;
    } cplx_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [OP_W-1:0]      operation;
    logic signed [DW-1:0] a_re, a_im, b_re, b_im;
    logic                 done;
    logic signed [DW-1:0] res_re, res_im;
    logic                 res_is_zero, res_is_real;
    logic [ST_W-1:0]      status;

    cplx_result_t pending_results[$];
    int           failures;
    int           send_idle_pct;
    longint       cycles;

    complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .done(done), .res_re(res_re), .res_im(res_im), .res_is_zero(res_is_zero),
        .res_is_real(res_is_real), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Clamp an exact value to the signed result range.
    function automatic longint clamp(input longint v, inout bit sat);
        longint hi, lo;
        hi = (64'sd1 <<< (DW-1)) - 1;
        lo = -(64'sd1 <<< (DW-1));
        if (v > hi)
        begin
            sat = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            sat = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // Scale num by 2^FB and divide, truncating toward zero; stop growing past the limit.
    function automatic longint scaled_quotient(input longint num, input longint den);
        longint unsigned q, r, m, d, lim;
        m = (num < 0) ? -num : num;
        d = den;
        lim = 64'd1 << (DW-1);
        q = m / d;
        r = m % d;
        for (int i = 0; i < FB; i++)
        begin
            if (q > lim)
                break;
            q = q << 1;
            r = r << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 1;
            end
        end
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint floor_sqrt(input longint n);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd4294967296;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= n)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic cplx_result_t compute_result(input logic [OP_W-1:0] op,
        input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
        input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi);
        longint xr, xi, yr, yi, rr, ri, den;
        bit sat;
        cplx_result_t r;
        xr = ar;
        xi = ai;
        yr = br;
        yi = bi;
        rr = 0;
        ri = 0;
        sat = 1'b0;
        r.st = ST_OK;
        case (op)
            OP_ADD:
            begin
                rr = clamp(xr + yr, sat);
                ri = clamp(xi + yi, sat);
            end
            OP_SUB:
            begin
                rr = clamp(xr - yr, sat);
                ri = clamp(xi - yi, sat);
            end
            OP_MUL:
            begin
                rr = clamp((xr*yr - xi*yi) >>> FB, sat);
                ri = clamp((yi*xr + xi*yr) >>> FB, sat);
            end
            OP_DIV:
            begin
                den = yr*yr + yi*yi;
                if (den == 0)
                    r.st = ST_DIVZ;
                else
                begin
                    rr = clamp(scaled_quotient(xr*yr + xi*yi, den), sat);
                    ri = clamp(scaled_quotient(xi*yr - xr*yi, den), sat);
                end
            end
            OP_CONJ:
            begin
                rr = xr;
                ri = clamp(-xi, sat);
            end
            OP_MAG:
                rr = clamp(floor_sqrt(xr*xr + xi*xi), sat);
            OP_MAG2:
                rr = clamp((xr*xr + xi*xi) >>> FB, sat);
            default:
            begin
            end
        endcase
        if (r.st == ST_OK && sat)
            r.st = ST_SAT;
        r.re = rr[DW-1:0];
        r.im = ri[DW-1:0];
        r.is_zero = (rr == 0 && ri == 0);
        r.is_real = (ri == 0);
        return r;
    endfunction

    task automatic send_transaction(input logic [OP_W-1:0] op,
        input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
        input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        a_re      <= ar;
        a_im      <= ai;
        b_re      <= br;
        b_im      <= bi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(compute_result(op, ar, ai, br, bi));
    endtask

    // Bias toward extremes and small values so saturation and zero cases recur.
    function automatic logic signed [DW-1:0] pick_value();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return DW'($signed($urandom_range(1024)) - 512);
            3: return 16'sd0;
            default: return DW'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        logic signed [DW-1:0] mx, mn;
        mx = 16'sh7FFF;
        mn = 16'sh8000;
        send_transaction(OP_ADD, mx, mx, mx, mx);
        send_transaction(OP_ADD, mn, mn, mn, mn);
        send_transaction(OP_SUB, mx, mn, mn, mx);
        send_transaction(OP_SUB, 16'sd256, 16'sd512, 16'sd256, 16'sd512);
        send_transaction(OP_MUL, mx, mx, mx, mn);
        send_transaction(OP_MUL, mn, mn, mn, mn);
        send_transaction(OP_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0);
        send_transaction(OP_MUL, 16'sd256, 16'sd256, 16'sd256, -16'sd256);
        send_transaction(OP_DIV, 16'sd256, 16'sd256, 16'sd0, 16'sd0);
        send_transaction(OP_DIV, mx, mn, 16'sd1, 16'sd0);
        send_transaction(OP_DIV, mn, mn, 16'sd0, -16'sd1);
        send_transaction(OP_DIV, 16'sd768, -16'sd256, 16'sd512, 16'sd256);
        send_transaction(OP_DIV, -16'sd1, 16'sd1, mx, mn);
        send_transaction(OP_CONJ, mn, mn, 16'sd0, 16'sd0);
        send_transaction(OP_CONJ, mx, mx, mx, mx);
        send_transaction(OP_MAG, mn, mn, 16'sd0, 16'sd0);
        send_transaction(OP_MAG, 16'sd768, 16'sd1024, 16'sd0, 16'sd0);
        send_transaction(OP_MAG, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_transaction(OP_MAG2, mn, mn, 16'sd0, 16'sd0);
        send_transaction(OP_MAG2, 16'sd1, -16'sd1, 16'sd0, 16'sd0);
        send_transaction(OP_UNUSED, mx, mn, mx, mn);
    endtask

    task automatic test_random(input int count, input int idle_pct);
        send_idle_pct = idle_pct;
        repeat (count)
            send_transaction(OP_W'($urandom_range(7)), pick_value(), pick_value(),
                             pick_value(), $urandom_range(3) == 0 ? 16'sd0 : pick_value());
    endtask

    always @(posedge clk)
    begin
        cplx_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected result re=%0d im=%0d", $time, res_re, res_im);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (res_re !== exp_r.re || res_im !== exp_r.im || res_is_zero !== exp_r.is_zero
                    || res_is_real !== exp_r.is_real || status !== exp_r.st)
                begin
                    failures++;
                    $display("%0t: expected re=%0d im=%0d z=%0b r=%0b st=%0d,",
                             $time, exp_r.re, exp_r.im, exp_r.is_zero, exp_r.is_real, exp_r.st,
                             " got re=%0d im=%0d z=%0b r=%0b st=%0d",
                             res_re, res_im, res_is_zero, res_is_real, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        failures = 0;
        cycles = 0;
        send_idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_ADD;
        a_re = '0;
        a_im = '0;
        b_re = '0;
        b_im = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(430, 13);
        test_random(430, 82);
        test_random(430, 0);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
